FILE: sv/sha1md_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha1md_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned BlockBits  = 512;
  localparam int unsigned CountBits  = 61;
  localparam int unsigned FillBits   = 6;
  localparam int unsigned RoundBits  = 7;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned DigestLen  = 20;
  localparam int unsigned EmitBits   = 5;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_item_t;

  typedef enum logic [1:0] {
    SEL_MSG  = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic                 shift_en;
    byte_sel_t            byte_sel;
    logic                 load_work;
    logic                 round_en;
    logic [RoundBits-1:0] round_idx;
    logic                 fold;
    logic                 emit;
    logic [EmitBits-1:0]  emit_idx;
    logic                 reinit;
  } dp_cmd_t;

  typedef struct packed {
    logic [FillBits-1:0] fill;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/sha1md_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1md_dp
  import sha1md_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_data_byte,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        stat,
  output logic [7:0]      digest_byte
);

  logic [BlockBits-1:0] block_r, block_nxt;
  logic [CountBits-1:0] count_r, count_nxt;
  logic [FillBits-1:0]  fill_r, fill_nxt;
  logic [31:0]          h_r [NumWords];
  logic [31:0]          a_r, b_r, c_r, d_r, e_r;
  logic [7:0]           byte_r;

  logic [7:0]  pad_byte;
  logic [63:0] bit_len;
  logic [31:0] f_val, k_val, t_val, w_new, w0;
  logic [31:0] emit_word;

  assign bit_len = {count_r, 3'b000};
  assign w0      = block_r[511:480];

  // Length bytes go in most significant first at fill 56..63.
  always_comb begin
    case (cmd.byte_sel)
      SEL_MSG:  pad_byte = in_data_byte;
      SEL_MARK: pad_byte = PAD_MARK;
      SEL_ZERO: pad_byte = 8'h00;
      SEL_LEN:  pad_byte = bit_len[{~fill_r[2:0], 3'b000} +: 8];
      default:  pad_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (cmd.round_idx < RoundBits'(20)) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K0;
    end else if (cmd.round_idx < RoundBits'(40)) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K1;
    end else if (cmd.round_idx < RoundBits'(60)) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w0;

  // Schedule taps: w[13], w[8], w[2], w[0] of the 16-word window.
  always_comb begin
    logic [31:0] x;
    x = block_r[95:64] ^ block_r[255:224] ^ block_r[447:416] ^ block_r[511:480];
    w_new = {x[30:0], x[31]};
  end

  always_comb begin
    block_nxt = block_r;
    count_nxt = count_r;
    fill_nxt  = fill_r;
    if (cmd.shift_en) begin
      block_nxt = {block_r[BlockBits-9:0], pad_byte};
      fill_nxt  = fill_r + FillBits'(1);
      if (cmd.byte_sel == SEL_MSG) begin
        count_nxt = count_r + CountBits'(1);
      end
    end else if (cmd.round_en) begin
      block_nxt = {block_r[BlockBits-33:0], w_new};
    end
    if (cmd.reinit) begin
      count_nxt = '0;
      fill_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fill_r  <= '0;
      h_r[0]  <= IV0;
      h_r[1]  <= IV1;
      h_r[2]  <= IV2;
      h_r[3]  <= IV3;
      h_r[4]  <= IV4;
    end else begin
      count_r <= count_nxt;
      fill_r  <= fill_nxt;
      if (cmd.fold) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end else if (cmd.reinit) begin
        h_r[0] <= IV0;
        h_r[1] <= IV1;
        h_r[2] <= IV2;
        h_r[3] <= IV3;
        h_r[4] <= IV4;
      end
    end
  end

  always_ff @(posedge clk) begin
    block_r <= block_nxt;
    if (cmd.load_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign emit_word = h_r[cmd.emit_idx[4:2]];

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_idx[1:0])
        2'd0:    byte_r <= emit_word[31:24];
        2'd1:    byte_r <= emit_word[23:16];
        2'd2:    byte_r <= emit_word[15:8];
        default: byte_r <= emit_word[7:0];
      endcase
    end
  end

  assign stat.fill   = fill_r;
  assign digest_byte = byte_r;

endmodule
`default_nettype wire

FILE: sv/sha1md_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     byte_valid,
  input  wire logic     end_of_message,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          out_valid,
  output logic          out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [RoundBits-1:0] rnd_r;
  logic [EmitBits-1:0]  idx_r;
  logic                 pend_r;
  logic                 padding_r;
  logic                 first_r;
  logic                 extra_r;
  logic                 out_valid_r;
  logic                 out_last_r;

  logic full_now;

  assign full_now = (stat.fill == {FillBits{1'b1}});

  always_comb begin
    cmd           = '0;
    cmd.byte_sel  = SEL_MSG;
    cmd.round_idx = rnd_r;
    cmd.emit_idx  = idx_r;
    case (state_r)
      S_IDLE: begin
        cmd.shift_en = start & byte_valid;
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        if (first_r) begin
          cmd.byte_sel = SEL_MARK;
        end else if ((stat.fill[5:3] == 3'b111) && !extra_r) begin
          cmd.byte_sel = SEL_LEN;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
      end
      S_LOAD:  cmd.load_work = 1'b1;
      S_ROUND: cmd.round_en = 1'b1;
      S_FOLD:  cmd.fold = 1'b1;
      S_EMIT: begin
        cmd.emit   = 1'b1;
        cmd.reinit = (idx_r == EmitBits'(DigestLen - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      padding_r   <= 1'b0;
      first_r     <= 1'b0;
      extra_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (byte_valid && full_now) begin
              state_r <= S_LOAD;
              pend_r  <= end_of_message;
            end else if (end_of_message) begin
              state_r   <= S_PAD;
              padding_r <= 1'b1;
              first_r   <= 1'b1;
            end
          end
        end
        S_PAD: begin
          first_r <= 1'b0;
          if (first_r) begin
            extra_r <= (stat.fill[5:3] == 3'b111);
          end
          if (full_now) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd_r   <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          rnd_r <= rnd_r + RoundBits'(1);
          if (rnd_r == RoundBits'(NumRounds - 1)) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (pend_r) begin
            pend_r    <= 1'b0;
            padding_r <= 1'b1;
            first_r   <= 1'b1;
            state_r   <= S_PAD;
          end else if (padding_r) begin
            if (extra_r) begin
              extra_r <= 1'b0;
              state_r <= S_PAD;
            end else begin
              idx_r   <= '0;
              state_r <= S_EMIT;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (idx_r == EmitBits'(DigestLen - 1));
          idx_r       <= idx_r + EmitBits'(1);
          if (idx_r == EmitBits'(DigestLen - 1)) begin
            padding_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

FILE: sv/sha1_message_digest.sv
// An ordinary byte is shifted in while idle; a byte that fills the 64-byte block
// starts a compression (work load, 80 rounds at one per cycle in the shared round
// unit, fold) with busy high. End item: padding shifts one byte per cycle to the
// block end (one or two blocks, each followed by a compression), then 20 digest
// bytes on consecutive cycles. The receiver cannot stall.
// Synchronous active-low reset restores the initial vector and zero byte count.
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       last;
  logic [7:0] digest_byte;

  sha1md_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .byte_valid     (in_item.byte_valid),
    .end_of_message (in_item.end_of_message),
    .stat           (stat),
    .cmd            (cmd),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_last       (last)
  );

  sha1md_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_item.data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .digest_byte  (digest_byte)
  );

  assign out_item.digest_byte = digest_byte;
  assign out_item.digest_last = last;

endmodule
`default_nettype wire

FILE: test/sha1_message_digest_tb.sv
`timescale 1ns / 1ps
module sha1_message_digest_tb;
  import sha1md_pkg::*;

  localparam logic [159:0] SHA1_INIT =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  sha1_message_digest dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Digest predictor state
  logic [31:0] hash_words [5];
  logic [7:0]  block_buf [64];
  logic [60:0] byte_count;

  out_item_t digest_bytes_due [$];
  out_item_t digest_want;
  int        errors = 0;
  int        sender_idle_pct = 0;
  int        message_items = 0;

  task automatic hash_restart();
    for (int i = 0; i < 5; i++) hash_words[i] = SHA1_INIT[159 - 32 * i -: 32];
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    byte_count = '0;
  endtask

  task automatic sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4 * i], block_buf[4 * i + 1], block_buf[4 * i + 2], block_buf[4 * i + 3]};
    for (int i = 16; i < 80; i++) begin
      t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
      w[i] = {t[30:0], t[31]};
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endtask

  task automatic sha1_absorb(input in_item_t item);
    int          pos;
    logic [63:0] bit_len;
    out_item_t   db;
    if (item.byte_valid) begin
      pos = int'(byte_count[5:0]);
      block_buf[pos] = item.data_byte;
      byte_count = byte_count + 61'd1;
      if (pos == 63) sha1_compress();
    end
    if (item.end_of_message) begin
      pos = int'(byte_count[5:0]);
      block_buf[pos] = 8'h80;
      for (int i = pos + 1; i < 64; i++) block_buf[i] = 8'h00;
      // no room for the length field: spill into a second block
      if (pos > 55) begin
        sha1_compress();
        for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      end
      bit_len = {byte_count, 3'b000};
      for (int i = 0; i < 8; i++) block_buf[63 - i] = bit_len[8 * i +: 8];
      sha1_compress();
      for (int i = 0; i < 20; i++) begin
        db.digest_byte = hash_words[i / 4][8 * (3 - i % 4) +: 8];
        db.digest_last = (i == 19);
        digest_bytes_due.push_back(db);
      end
      hash_restart();
    end
  endtask

  function automatic in_item_t msg_item(input logic [7:0] data, input logic valid,
                                        input logic eom);
    in_item_t item;
    item.data_byte      = data;
    item.byte_valid     = valid;
    item.end_of_message = eom;
    return item;
  endfunction

  // Called at a falling edge; returns at a falling edge with start still high.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sha1_absorb(item);
    @(negedge clk);
  endtask

  task automatic stop_driving();
    start <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_digests_done();
    while (digest_bytes_due.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (digest_bytes_due.size() == 0) begin
        $display("%0t: unexpected digest item, expected none, got byte %02h last %0b",
                 $time, out_item.digest_byte, out_item.digest_last);
        errors++;
      end else begin
        digest_want = digest_bytes_due.pop_front();
        if (out_item.digest_byte !== digest_want.digest_byte) begin
          $display("%0t: digest_byte expected %02h got %02h",
                   $time, digest_want.digest_byte, out_item.digest_byte);
          errors++;
        end
        if (out_item.digest_last !== digest_want.digest_last) begin
          $display("%0t: digest_last expected %0b got %0b",
                   $time, digest_want.digest_last, out_item.digest_last);
          errors++;
        end
      end
    end
  end

  // Random bytes with an occasional no-op item slipped in.
  task automatic send_message(input int len, input bit end_alone);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(99) < 8)
        send_item(msg_item(8'($urandom_range(255)), 1'b0, 1'b0));
      send_item(msg_item(8'($urandom_range(255)), 1'b1, (n == len - 1) && !end_alone));
    end
    if (len == 0 || end_alone) begin
      send_item(msg_item(8'($urandom_range(255)), 1'b0, 1'b1));
      message_items++;
    end
    message_items += len;
  endtask

  task automatic test_empty_message();
    sender_idle_pct = 0;
    send_item(msg_item(8'hA5, 1'b0, 1'b1));
    send_item(msg_item(8'h00, 1'b0, 1'b1));
    stop_driving();
    wait_digests_done();
  endtask

  task automatic test_noop_items();
    send_item(msg_item(8'hFF, 1'b0, 1'b0));
    send_item(msg_item(8'h00, 1'b0, 1'b0));
    send_item(msg_item(8'hFF, 1'b0, 1'b1));
    stop_driving();
    wait_digests_done();
  endtask

  task automatic test_byte_with_end();
    send_item(msg_item(8'h61, 1'b1, 1'b0));
    send_item(msg_item(8'h62, 1'b1, 1'b0));
    send_item(msg_item(8'h63, 1'b1, 1'b1));
    send_item(msg_item(8'hFF, 1'b1, 1'b1));
    send_item(msg_item(8'h00, 1'b1, 1'b1));
    stop_driving();
    wait_digests_done();
  endtask

  task automatic test_end_after_bytes();
    sender_idle_pct = 50;
    send_item(msg_item(8'h00, 1'b1, 1'b0));
    send_item(msg_item(8'hFF, 1'b1, 1'b0));
    send_item(msg_item(8'h00, 1'b0, 1'b1));
    stop_driving();
    wait_digests_done();
  endtask

  // Open with a message whose length lands on a padding boundary, then mix.
  task automatic test_random_messages(input int idle_pct, input int first_len,
                                      input bit first_end_alone);
    int target;
    int len;
    sender_idle_pct = idle_pct;
    target = message_items + 35;
    if (first_len >= 0) send_message(first_len, first_end_alone);
    while (message_items < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 12);
      send_message(len, 1'($urandom_range(1)));
    end
    stop_driving();
    wait_digests_done();
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    hash_restart();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_message();
    test_noop_items();
    test_byte_with_end();
    test_end_after_bytes();
    test_random_messages(0, 56, 1'b0);
    test_random_messages(85, 55, 1'b0);
    test_random_messages(35, 64, 1'b1);

    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
